// ===== design/fmcd_pkg.sv =====
`default_nettype none

package fmcd_pkg;

    localparam int unsigned MAX_FRAME_PIXELS_DEF = 1048576;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 21;
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned RANGE_W    = 8;
    localparam int unsigned SENS_W     = 16;
    localparam int unsigned FP_W       = 21;
    localparam int unsigned HUE_W      = 9;
    localparam int unsigned SAT_W      = 9;
    localparam int unsigned JUMP_W     = 21;
    localparam int unsigned H6_W       = 11;
    localparam int unsigned NUM_W      = 17;
    localparam int unsigned SATL_W     = 16;

    localparam logic [RANGE_W-1:0] DIFF_RANGE_RST   = RANGE_W'(30);
    localparam logic [SENS_W-1:0]  SENSITIVITY_RST  = SENS_W'(10);
    localparam logic [FP_W-1:0]    FRAME_PIXELS_RST = FP_W'(307200);
    localparam logic [HUE_W-1:0]   HUE_LOW_RST      = HUE_W'(40);
    localparam logic [HUE_W-1:0]   HUE_HIGH_RST     = HUE_W'(70);
    localparam logic [SAT_W-1:0]   SAT_MIN_RST      = SAT_W'(128);
    localparam logic [JUMP_W-1:0]  SHOT_JUMP_RST    = JUMP_W'(5000);

    // Fixed color bounds: 1.5 * 255 rounded up and 0.55 * 255 rounded down.
    localparam logic [PIX_W:0]     RG_SUM_MIN = 9'd383;
    localparam logic [PIX_W-1:0]   BLUE_MAX   = 8'd140;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DIFF_RANGE   = 3'd0,
        CFG_SENSITIVITY  = 3'd1,
        CFG_FRAME_PIXELS = 3'd2,
        CFG_HUE_LOW      = 3'd3,
        CFG_HUE_HIGH     = 3'd4,
        CFG_SAT_MIN      = 3'd5,
        CFG_SHOT_JUMP    = 3'd6
    } t_cfg_addr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX,
        ST_MUL,
        ST_CMP,
        ST_FMUL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic mix;
        logic mul;
        logic cmp;
        logic fmul;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== design/fmcd_ctrl.sv =====
`default_nettype none

module fmcd_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  fmcd_pkg::t_dp_stat      i_stat,
    output fmcd_pkg::t_dp_cmd       o_cmd,
    output logic                    o_in_stall
);
    import fmcd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MIX;
                end
            end
            ST_MIX: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                n_state = i_stat.last ? ST_FMUL : ST_EMIT;
            end
            ST_FMUL: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_in_stall    = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            ST_MIX: begin
                o_cmd.mix = 1'b1;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
            end
            ST_FMUL: begin
                o_cmd.fmul = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/fmcd_dp.sv =====
`default_nettype none

module fmcd_dp #(
    parameter int unsigned MAX_FRAME_PIXELS = fmcd_pkg::MAX_FRAME_PIXELS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [fmcd_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [fmcd_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data,
    input  wire logic [fmcd_pkg::PIX_W-1:0]          i_cur_red,
    input  wire logic [fmcd_pkg::PIX_W-1:0]          i_cur_green,
    input  wire logic [fmcd_pkg::PIX_W-1:0]          i_cur_blue,
    input  wire logic [fmcd_pkg::PIX_W-1:0]          i_ref_red,
    input  wire logic [fmcd_pkg::PIX_W-1:0]          i_ref_green,
    input  wire logic [fmcd_pkg::PIX_W-1:0]          i_ref_blue,
    input  wire logic                                i_frame_end,
    input  wire logic                                i_out_stall,
    input  fmcd_pkg::t_dp_cmd                        i_cmd,
    output fmcd_pkg::t_dp_stat                       o_stat,
    output logic                                     o_out_valid,
    output logic                                     o_mask_on,
    output logic                                     o_frame_done,
    output logic                                     o_motion_seen,
    output logic                                     o_shot_seen
);
    import fmcd_pkg::*;

    localparam int unsigned CNT_W  = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int unsigned CMP_W  = (CNT_W > FP_W) ? CNT_W : FP_W;
    localparam int unsigned PROD_W = CNT_W + SENS_W;
    localparam int unsigned EXT_W  = (PROD_W > FP_W) ? PROD_W : FP_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_PIXELS);
    localparam logic [CMP_W-1:0] MAX_FP  = CMP_W'(MAX_FRAME_PIXELS);

    logic [RANGE_W-1:0] r_diff_range;
    logic [SENS_W-1:0]  r_sensitivity;
    logic [FP_W-1:0]    r_frame_pixels;
    logic [HUE_W-1:0]   r_hue_low;
    logic [HUE_W-1:0]   r_hue_high;
    logic [SAT_W-1:0]   r_sat_min;
    logic [JUMP_W-1:0]  r_shot_jump;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_range   <= DIFF_RANGE_RST;
            r_sensitivity  <= SENSITIVITY_RST;
            r_frame_pixels <= FRAME_PIXELS_RST;
            r_hue_low      <= HUE_LOW_RST;
            r_hue_high     <= HUE_HIGH_RST;
            r_sat_min      <= SAT_MIN_RST;
            r_shot_jump    <= SHOT_JUMP_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_DIFF_RANGE:   r_diff_range   <= i_cfg_wr_data[RANGE_W-1:0];
                CFG_SENSITIVITY:  r_sensitivity  <= i_cfg_wr_data[SENS_W-1:0];
                CFG_FRAME_PIXELS: r_frame_pixels <= i_cfg_wr_data[FP_W-1:0];
                CFG_HUE_LOW:      r_hue_low      <= i_cfg_wr_data[HUE_W-1:0];
                CFG_HUE_HIGH:     r_hue_high     <= i_cfg_wr_data[HUE_W-1:0];
                CFG_SAT_MIN:      r_sat_min      <= i_cfg_wr_data[SAT_W-1:0];
                CFG_SHOT_JUMP:    r_shot_jump    <= i_cfg_wr_data[JUMP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic [PIX_W-1:0] r_cur_r;
    logic [PIX_W-1:0] r_cur_g;
    logic [PIX_W-1:0] r_cur_b;
    logic [PIX_W-1:0] r_ref_r;
    logic [PIX_W-1:0] r_ref_g;
    logic [PIX_W-1:0] r_ref_b;
    logic             r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cur_r <= i_cur_red;
            r_cur_g <= i_cur_green;
            r_cur_b <= i_cur_blue;
            r_ref_r <= i_ref_red;
            r_ref_g <= i_ref_green;
            r_ref_b <= i_ref_blue;
            r_last  <= i_frame_end;
        end
    end

    // Channel differences, extremes and the hue numerator in units of d / 6.
    logic [PIX_W-1:0] n_dr;
    logic [PIX_W-1:0] n_dg;
    logic [PIX_W-1:0] n_db;
    logic [PIX_W-1:0] n_mx;
    logic [PIX_W-1:0] n_mn;
    logic [PIX_W-1:0] n_d;
    logic [H6_W-1:0]  n_d6;
    logic [H6_W-1:0]  n_h6;
    logic             n_changed;

    always_comb begin
        n_dr = (r_cur_r > r_ref_r) ? r_cur_r - r_ref_r : r_ref_r - r_cur_r;
        n_dg = (r_cur_g > r_ref_g) ? r_cur_g - r_ref_g : r_ref_g - r_cur_g;
        n_db = (r_cur_b > r_ref_b) ? r_cur_b - r_ref_b : r_ref_b - r_cur_b;
        n_changed = (n_dr >= r_diff_range) || (n_dg >= r_diff_range) ||
                    (n_db >= r_diff_range);

        n_mx = r_cur_r;
        if (r_cur_g > n_mx) n_mx = r_cur_g;
        if (r_cur_b > n_mx) n_mx = r_cur_b;
        n_mn = r_cur_r;
        if (r_cur_g < n_mn) n_mn = r_cur_g;
        if (r_cur_b < n_mn) n_mn = r_cur_b;
        n_d  = n_mx - n_mn;
        n_d6 = {1'b0, n_d, 2'b00} + {2'b00, n_d, 1'b0};

        priority if (r_cur_r == n_mx) begin
            n_h6 = H6_W'(r_cur_g) - H6_W'(r_cur_b) +
                   ((r_cur_g < r_cur_b) ? n_d6 : '0);
        end else if (r_cur_g == n_mx) begin
            n_h6 = {2'b00, n_d, 1'b0} + H6_W'(r_cur_b) - H6_W'(r_cur_r);
        end else begin
            n_h6 = {1'b0, n_d, 2'b00} + H6_W'(r_cur_r) - H6_W'(r_cur_g);
        end
    end

    logic             r_changed;
    logic [PIX_W-1:0] r_mx;
    logic [PIX_W-1:0] r_d;
    logic [H6_W-1:0]  r_h6;
    logic             r_rg_ok;
    logic             r_b_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix) begin
            r_changed <= n_changed;
            r_mx      <= n_mx;
            r_d       <= n_d;
            r_h6      <= n_h6;
            r_rg_ok   <= ({1'b0, r_cur_r} + {1'b0, r_cur_g}) >= RG_SUM_MIN;
            r_b_ok    <= r_cur_b <= BLUE_MAX;
        end
    end

    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_lo;
    logic [NUM_W-1:0] r_hi;
    logic [NUM_W-1:0] r_sat_rhs;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_num     <= {r_h6, 6'b000000} - NUM_W'({r_h6, 2'b00});
            r_lo      <= NUM_W'(r_hue_low) * NUM_W'(r_d);
            r_hi      <= NUM_W'(r_hue_high) * NUM_W'(r_d);
            r_sat_rhs <= NUM_W'(r_sat_min) * NUM_W'(r_mx);
        end
    end

    logic [SATL_W-1:0] n_sat_lhs;
    logic              n_hue_ok;
    logic              n_sat_ok;
    logic              n_hit;

    always_comb begin
        n_sat_lhs = {r_d, 8'h00};
        if (r_d == '0) begin
            n_hue_ok = (r_hue_low == '0);
            n_sat_ok = (r_sat_min == '0);
        end else begin
            n_hue_ok = (r_num >= r_lo) && (r_num <= r_hi);
            n_sat_ok = NUM_W'(n_sat_lhs) >= r_sat_rhs;
        end
        n_hit = n_hue_ok && n_sat_ok && r_rg_ok && r_b_ok;
    end

    logic              r_hit;
    logic [CNT_W-1:0]  r_chg_cnt;
    logic [CNT_W-1:0]  r_mask_cnt;
    logic [CNT_W-1:0]  r_prior_cnt;
    logic [PROD_W-1:0] r_prod;
    logic [SENS_W-1:0] n_sens;
    logic [CMP_W-1:0]  n_fp;
    logic [CNT_W-1:0]  n_rise;
    logic              n_motion;
    logic              n_shot;

    always_comb begin
        n_sens   = (r_sensitivity == '0) ? SENS_W'(1) : r_sensitivity;
        n_fp     = (CMP_W'(r_frame_pixels) > MAX_FP) ? MAX_FP : CMP_W'(r_frame_pixels);
        // Count above floor(fp / sens) is the same as count * sens above fp.
        n_motion = r_last && (EXT_W'(r_prod) > EXT_W'(n_fp));
        n_rise   = r_mask_cnt - r_prior_cnt;
        n_shot   = r_last && (r_mask_cnt > r_prior_cnt) &&
                   (CMP_W'(n_rise) > CMP_W'(r_shot_jump));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chg_cnt   <= '0;
            r_mask_cnt  <= '0;
            r_prior_cnt <= '0;
        end else if (i_cmd.cmp) begin
            if (r_changed && (r_chg_cnt < MAX_CNT)) begin
                r_chg_cnt <= r_chg_cnt + CNT_W'(1);
            end
            if (n_hit && (r_mask_cnt < MAX_CNT)) begin
                r_mask_cnt <= r_mask_cnt + CNT_W'(1);
            end
        end else if (i_cmd.emit && r_last) begin
            r_prior_cnt <= r_mask_cnt;
            r_chg_cnt   <= '0;
            r_mask_cnt  <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_hit <= n_hit;
        end
        if (i_cmd.fmul) begin
            r_prod <= PROD_W'(r_chg_cnt) * PROD_W'(n_sens);
        end
    end

    logic r_out_valid;
    logic r_out_mask;
    logic r_out_done;
    logic r_out_motion;
    logic r_out_shot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_mask   <= r_hit;
            r_out_done   <= r_last;
            r_out_motion <= n_motion;
            r_out_shot   <= n_shot;
        end
    end

    assign o_stat.last     = r_last;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_mask_on       = r_out_mask;
    assign o_frame_done    = r_out_done;
    assign o_motion_seen   = r_out_motion;
    assign o_shot_seen     = r_out_shot;

endmodule

`default_nettype wire

// ===== design/frame_motion_and_color_detector.sv =====
// Channel  Direction  Handshake              Payload
// pixel    in         i_in_valid/o_in_stall  i_cur_*, i_ref_*, i_frame_end
// result   out        o_out_valid/i_out_stall o_mask_on, o_frame_done,
//                                             o_motion_seen, o_shot_seen
// config   in         i_cfg_wr_en            i_cfg_addr, i_cfg_wr_data
//
// A pixel passes from transfer to result through the controller's states MIX,
// MUL and CMP, then FMUL with the frame-end multiplier on a frame's last pixel,
// then EMIT, which waits for a free output register. The next pixel is taken
// while a result waits there. Reset is synchronous: configuration registers
// return to their default values and all counts to zero. A stalled result holds
// the last state until the output register frees; the pixel channel stalls meanwhile.
`default_nettype none

module frame_motion_and_color_detector #(
    parameter int unsigned MAX_FRAME_PIXELS = fmcd_pkg::MAX_FRAME_PIXELS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [fmcd_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [fmcd_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [fmcd_pkg::PIX_W-1:0]          i_cur_red,
    input  wire logic [fmcd_pkg::PIX_W-1:0]          i_cur_green,
    input  wire logic [fmcd_pkg::PIX_W-1:0]          i_cur_blue,
    input  wire logic [fmcd_pkg::PIX_W-1:0]          i_ref_red,
    input  wire logic [fmcd_pkg::PIX_W-1:0]          i_ref_green,
    input  wire logic [fmcd_pkg::PIX_W-1:0]          i_ref_blue,
    input  wire logic                                i_frame_end,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_mask_on,
    output logic                                     o_frame_done,
    output logic                                     o_motion_seen,
    output logic                                     o_shot_seen
);
    import fmcd_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    fmcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    fmcd_dp #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cur_red     (i_cur_red),
        .i_cur_green   (i_cur_green),
        .i_cur_blue    (i_cur_blue),
        .i_ref_red     (i_ref_red),
        .i_ref_green   (i_ref_green),
        .i_ref_blue    (i_ref_blue),
        .i_frame_end   (i_frame_end),
        .i_out_stall   (i_out_stall),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_out_valid   (o_out_valid),
        .o_mask_on     (o_mask_on),
        .o_frame_done  (o_frame_done),
        .o_motion_seen (o_motion_seen),
        .o_shot_seen   (o_shot_seen)
    );

endmodule

`default_nettype wire

// ===== design/fmcd_chk.sv =====
`default_nettype none

module fmcd_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_stall,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire logic o_mask_on,
    input wire logic o_frame_done,
    input wire logic o_motion_seen,
    input wire logic o_shot_seen
);

    // A pixel transfer is always followed by a busy cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("pixel channel open right after a transfer");

    // Frame flags appear only on a frame's last result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_done) |-> (!o_motion_seen && !o_shot_seen))
        else $error("frame flag set on a result that ends no frame");

    // A new result is loaded only while the pixel channel is busy.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a pixel in work");

    // A stalled result stays valid and unchanged.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_mask_on) && $stable(o_frame_done) &&
             $stable(o_motion_seen) && $stable(o_shot_seen)))
        else $error("stalled result changed");

endmodule

bind frame_motion_and_color_detector fmcd_chk u_fmcd_chk (.*);

`default_nettype wire

// ===== tb/motion_mask_checker.sv =====
`timescale 1ns / 1ps

module motion_mask_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [fmcd_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [fmcd_pkg::CFG_DATA_W-1:0]    i_cfg_wr_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [fmcd_pkg::PIX_W-1:0]         i_cur_red,
    input  logic [fmcd_pkg::PIX_W-1:0]         i_cur_green,
    input  logic [fmcd_pkg::PIX_W-1:0]         i_cur_blue,
    input  logic [fmcd_pkg::PIX_W-1:0]         i_ref_red,
    input  logic [fmcd_pkg::PIX_W-1:0]         i_ref_green,
    input  logic [fmcd_pkg::PIX_W-1:0]         i_ref_blue,
    input  logic                               i_frame_end,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic                               i_mask_on,
    input  logic                               i_frame_done,
    input  logic                               i_motion_seen,
    input  logic                               i_shot_seen,
    output int                                 o_fail_count,
    output int                                 o_outstanding
);

    import fmcd_pkg::*;

    typedef struct packed {
        logic mask_on;
        logic frame_done;
        logic motion_seen;
        logic shot_seen;
    } t_pixel_verdict;

    t_pixel_verdict awaited_verdicts[$];

    logic [RANGE_W-1:0] diff_range_q;
    logic [SENS_W-1:0]  sensitivity_q;
    logic [FP_W-1:0]    frame_pixels_q;
    logic [HUE_W-1:0]   hue_low_q;
    logic [HUE_W-1:0]   hue_high_q;
    logic [SAT_W-1:0]   sat_min_q;
    logic [JUMP_W-1:0]  shot_jump_q;

    int unsigned changed_pixels;
    int unsigned masked_pixels;
    int unsigned prior_masked_pixels;

    int fail_total;

    function automatic int chan_delta(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    function automatic int unsigned bump(input int unsigned count);
        return (count < MAX_FRAME_PIXELS_DEF) ? count + 1 : count;
    endfunction

    function automatic logic color_band_hit(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                            input logic [PIX_W-1:0] b);
        int   ri;
        int   gi;
        int   bi;
        int   mx;
        int   mn;
        int   d;
        int   num;
        logic hue_ok;
        logic sat_ok;
        ri = int'(r);
        gi = int'(g);
        bi = int'(b);
        mx = ri;
        mn = ri;
        if (gi > mx) mx = gi;
        if (bi > mx) mx = bi;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        d = mx - mn;
        if (d == 0) begin
            hue_ok = (hue_low_q == '0);
            sat_ok = (sat_min_q == '0);
        end else begin
            if (ri == mx) begin
                num = 60 * (gi - bi);
            end else if (gi == mx) begin
                num = 60 * (2 * d + bi - ri);
            end else begin
                num = 60 * (4 * d + ri - gi);
            end
            if (num < 0) num = num + 360 * d;
            hue_ok = (num >= int'(hue_low_q) * d) && (num <= int'(hue_high_q) * d);
            sat_ok = (256 * d >= int'(sat_min_q) * mx);
        end
        return hue_ok && sat_ok && (ri + gi >= int'(RG_SUM_MIN)) && (bi <= int'(BLUE_MAX));
    endfunction

    function automatic t_pixel_verdict grade_pixel(input logic [PIX_W-1:0] r,
                                                   input logic [PIX_W-1:0] g,
                                                   input logic [PIX_W-1:0] b,
                                                   input logic [PIX_W-1:0] rr,
                                                   input logic [PIX_W-1:0] rg,
                                                   input logic [PIX_W-1:0] rb,
                                                   input logic last);
        t_pixel_verdict v;
        int unsigned    fp;
        int unsigned    sens;
        v = '0;
        if (chan_delta(r, rr) >= int'(diff_range_q) || chan_delta(g, rg) >= int'(diff_range_q) ||
            chan_delta(b, rb) >= int'(diff_range_q)) begin
            changed_pixels = bump(changed_pixels);
        end
        v.mask_on = color_band_hit(r, g, b);
        if (v.mask_on) masked_pixels = bump(masked_pixels);
        v.frame_done = last;
        if (last) begin
            fp = 32'(frame_pixels_q);
            if (fp > MAX_FRAME_PIXELS_DEF) fp = MAX_FRAME_PIXELS_DEF;
            sens = (sensitivity_q == '0) ? 32'd1 : 32'(sensitivity_q);
            v.motion_seen = (changed_pixels > fp / sens);
            v.shot_seen = (masked_pixels > prior_masked_pixels) &&
                          (masked_pixels - prior_masked_pixels > 32'(shot_jump_q));
            prior_masked_pixels = masked_pixels;
            changed_pixels = 0;
            masked_pixels = 0;
        end
        return v;
    endfunction

    task automatic check_bit(input string label, input logic want, input logic got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, label, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_verdict want;
        if (!i_rst_n) begin
            diff_range_q        = DIFF_RANGE_RST;
            sensitivity_q       = SENSITIVITY_RST;
            frame_pixels_q      = FRAME_PIXELS_RST;
            hue_low_q           = HUE_LOW_RST;
            hue_high_q          = HUE_HIGH_RST;
            sat_min_q           = SAT_MIN_RST;
            shot_jump_q         = SHOT_JUMP_RST;
            changed_pixels      = 0;
            masked_pixels       = 0;
            prior_masked_pixels = 0;
            awaited_verdicts.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_addr'(i_cfg_addr))
                    CFG_DIFF_RANGE:   diff_range_q   = i_cfg_wr_data[RANGE_W-1:0];
                    CFG_SENSITIVITY:  sensitivity_q  = i_cfg_wr_data[SENS_W-1:0];
                    CFG_FRAME_PIXELS: frame_pixels_q = i_cfg_wr_data[FP_W-1:0];
                    CFG_HUE_LOW:      hue_low_q      = i_cfg_wr_data[HUE_W-1:0];
                    CFG_HUE_HIGH:     hue_high_q     = i_cfg_wr_data[HUE_W-1:0];
                    CFG_SAT_MIN:      sat_min_q      = i_cfg_wr_data[SAT_W-1:0];
                    CFG_SHOT_JUMP:    shot_jump_q    = i_cfg_wr_data[JUMP_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_verdicts.push_back(grade_pixel(i_cur_red, i_cur_green, i_cur_blue,
                                                       i_ref_red, i_ref_green, i_ref_blue,
                                                       i_frame_end));
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited_verdicts.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %b%b%b%b",
                             $time, i_mask_on, i_frame_done, i_motion_seen, i_shot_seen);
                    fail_total++;
                end else begin
                    want = awaited_verdicts.pop_front();
                    check_bit("mask_on", want.mask_on, i_mask_on);
                    check_bit("frame_done", want.frame_done, i_frame_done);
                    check_bit("motion_seen", want.motion_seen, i_motion_seen);
                    check_bit("shot_seen", want.shot_seen, i_shot_seen);
                end
            end
        end
        o_fail_count  = fail_total;
        o_outstanding = awaited_verdicts.size();
    end

endmodule

// ===== tb/tb_frame_motion_and_color_detector.sv =====
`timescale 1ns / 1ps

module tb_frame_motion_and_color_detector;

    import fmcd_pkg::*;

    typedef struct {
        logic [CFG_DATA_W-1:0] diff_range;
        logic [CFG_DATA_W-1:0] sensitivity;
        logic [CFG_DATA_W-1:0] frame_pixels;
        logic [CFG_DATA_W-1:0] hue_low;
        logic [CFG_DATA_W-1:0] hue_high;
        logic [CFG_DATA_W-1:0] sat_min;
        logic [CFG_DATA_W-1:0] shot_jump;
    } t_settings;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [PIX_W-1:0]      i_cur_red;
    logic [PIX_W-1:0]      i_cur_green;
    logic [PIX_W-1:0]      i_cur_blue;
    logic [PIX_W-1:0]      i_ref_red;
    logic [PIX_W-1:0]      i_ref_green;
    logic [PIX_W-1:0]      i_ref_blue;
    logic                  i_frame_end;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_mask_on;
    logic                  o_frame_done;
    logic                  o_motion_seen;
    logic                  o_shot_seen;

    int fail_count;
    int pending_results;
    int pixels_sent;
    bit quiet_phase;

    frame_motion_and_color_detector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cur_red     (i_cur_red),
        .i_cur_green   (i_cur_green),
        .i_cur_blue    (i_cur_blue),
        .i_ref_red     (i_ref_red),
        .i_ref_green   (i_ref_green),
        .i_ref_blue    (i_ref_blue),
        .i_frame_end   (i_frame_end),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_mask_on     (o_mask_on),
        .o_frame_done  (o_frame_done),
        .o_motion_seen (o_motion_seen),
        .o_shot_seen   (o_shot_seen)
    );

    motion_mask_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_cur_red     (i_cur_red),
        .i_cur_green   (i_cur_green),
        .i_cur_blue    (i_cur_blue),
        .i_ref_red     (i_ref_red),
        .i_ref_green   (i_ref_green),
        .i_ref_blue    (i_ref_blue),
        .i_frame_end   (i_frame_end),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_mask_on     (o_mask_on),
        .i_frame_done  (o_frame_done),
        .i_motion_seen (o_motion_seen),
        .i_shot_seen   (o_shot_seen),
        .o_fail_count  (fail_count),
        .o_outstanding (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int hold;
        hold = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (quiet_phase || $urandom_range(0, 1) == 0) begin
                i_out_stall = 1'b0;
                hold = quiet_phase ? 0 : $urandom_range(0, 4);
            end else begin
                i_out_stall = 1'b1;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 2);
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_phase || roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] maybe_raw(input int unsigned typical);
        logic [CFG_DATA_W-1:0] raw;
        raw = CFG_DATA_W'($urandom);
        return ($urandom_range(0, 7) == 0) ? raw : CFG_DATA_W'(typical);
    endfunction

    function automatic t_settings random_settings();
        t_settings s;
        int unsigned lo;
        lo = $urandom_range(0, 90);
        s.diff_range   = maybe_raw($urandom_range(0, 60));
        s.sensitivity  = maybe_raw($urandom_range(0, 4));
        s.frame_pixels = maybe_raw($urandom_range(1, 30));
        s.hue_low      = maybe_raw(lo);
        s.hue_high     = maybe_raw(lo + $urandom_range(0, 120));
        s.sat_min      = maybe_raw($urandom_range(0, 256));
        s.shot_jump    = maybe_raw($urandom_range(0, 5));
        return s;
    endfunction

    task automatic write_reg(input t_cfg_addr idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_addr    = idx;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic program_settings(input t_settings s);
        write_reg(CFG_DIFF_RANGE, s.diff_range);
        write_reg(CFG_SENSITIVITY, s.sensitivity);
        write_reg(CFG_FRAME_PIXELS, s.frame_pixels);
        write_reg(CFG_HUE_LOW, s.hue_low);
        write_reg(CFG_HUE_HIGH, s.hue_high);
        write_reg(CFG_SAT_MIN, s.sat_min);
        write_reg(CFG_SHOT_JUMP, s.shot_jump);
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] cr, input logic [PIX_W-1:0] cg,
                              input logic [PIX_W-1:0] cb, input logic [PIX_W-1:0] rr,
                              input logic [PIX_W-1:0] rg, input logic [PIX_W-1:0] rb,
                              input logic last);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cur_red   = cr;
        i_cur_green = cg;
        i_cur_blue  = cb;
        i_ref_red   = rr;
        i_ref_green = rg;
        i_ref_blue  = rb;
        i_frame_end = last;
        i_in_valid  = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pixels_sent++;
    endtask

    task automatic push_random_pixel(input logic last);
        logic [PIX_W-1:0] c[3];
        logic [PIX_W-1:0] rf[3];
        int               kind;
        int               v;
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            c[0] = PIX_W'($urandom_range(180, 255));
            c[1] = PIX_W'($urandom_range(180, 255));
            c[2] = PIX_W'($urandom_range(0, 150));
        end else if (kind <= 6) begin
            c[0] = PIX_W'($urandom);
            c[1] = PIX_W'($urandom);
            c[2] = PIX_W'($urandom);
        end else if (kind == 7) begin
            c[0] = PIX_W'($urandom);
            c[1] = c[0];
            c[2] = c[0];
        end else if (kind == 8) begin
            c[0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            c[1] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            c[2] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else begin
            c[0] = PIX_W'($urandom_range(128, 255));
            v = 383 - int'(c[0]) + int'($urandom_range(0, 2)) - 1;
            c[1] = (v > 255) ? 8'hFF : PIX_W'(v);
            c[2] = PIX_W'($urandom_range(138, 142));
        end
        kind = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
            if (kind == 0) begin
                rf[k] = c[k];
            end else if (kind == 1) begin
                v = int'(c[k]) + int'($urandom_range(0, 80)) - 40;
                rf[k] = (v < 0) ? 8'h00 : (v > 255) ? 8'hFF : PIX_W'(v);
            end else begin
                rf[k] = PIX_W'($urandom);
            end
        end
        push_pixel(c[0], c[1], c[2], rf[0], rf[1], rf[2], last);
    endtask

    task automatic run_frames(input int target);
        int count;
        int len;
        count = 0;
        while (count < target) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            for (int i = 0; i < len; i++) push_random_pixel(i == len - 1);
            count += len;
        end
    endtask

    task automatic settle(input int extra);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    initial begin
        t_settings s;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_addr    = CFG_DIFF_RANGE;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_cur_red     = '0;
        i_cur_green   = '0;
        i_cur_blue    = '0;
        i_ref_red     = '0;
        i_ref_green   = '0;
        i_ref_blue    = '0;
        i_frame_end   = 1'b0;
        quiet_phase   = 1'b0;
        pixels_sent   = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        s = '{30, 2, 8, 40, 70, 200, 0};
        program_settings(s);
        push_pixel(0, 0, 0, 0, 0, 0, 0);
        push_pixel(255, 255, 255, 0, 0, 0, 0);
        push_pixel(255, 255, 0, 255, 255, 0, 0);
        push_pixel(255, 0, 0, 255, 0, 30, 0);
        push_pixel(0, 255, 0, 0, 255, 29, 0);
        push_pixel(0, 0, 255, 0, 0, 255, 0);
        push_pixel(255, 0, 255, 0, 0, 0, 0);
        push_pixel(0, 255, 255, 0, 0, 0, 1);
        push_pixel(192, 191, 0, 0, 0, 0, 0);
        push_pixel(192, 190, 0, 0, 0, 0, 0);
        push_pixel(255, 255, 55, 0, 0, 0, 0);
        push_pixel(255, 255, 56, 0, 0, 0, 0);
        push_pixel(255, 255, 140, 0, 0, 0, 0);
        push_pixel(255, 255, 141, 0, 0, 0, 0);
        push_pixel(255, 170, 0, 0, 0, 0, 0);
        push_pixel(255, 169, 0, 0, 0, 0, 0);
        push_pixel(200, 240, 0, 0, 0, 0, 0);
        push_pixel(201, 240, 0, 0, 0, 0, 0);
        push_pixel(199, 240, 0, 0, 0, 0, 1);
        push_pixel(128, 128, 128, 128, 128, 128, 1);
        settle(10);

        s = '{0, 0, 1, 0, 360, 0, 0};
        program_settings(s);
        run_frames(60);
        settle(10);

        s = '{255, 65535, 21'h1FFFFF, 9'h1FF, 9'h1FF, 9'h1FF, 21'h1FFFFF};
        program_settings(s);
        run_frames(60);
        settle(10);

        s = '{1, 1, 1048576, 70, 40, 256, 1048576};
        program_settings(s);
        run_frames(60);
        settle(10);

        while (pixels_sent < 1300) begin
            quiet_phase = ($urandom_range(0, 3) == 0);
            program_settings(random_settings());
            run_frames($urandom_range(60, 140));
            settle(10);
        end

        settle(20);
        if (fail_count == 0 && pending_results == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/fmcd_pkg.sv
design/fmcd_ctrl.sv
design/fmcd_dp.sv
design/frame_motion_and_color_detector.sv
design/fmcd_chk.sv
tb/motion_mask_checker.sv
tb/tb_frame_motion_and_color_detector.sv
